// ===== hdl/bus_frame_checker_core_assert.svh =====
// Assertion macros for the checking file of the frame checker.
`ifndef BUS_FRAME_CHECKER_CORE_ASSERT_SVH
`define BUS_FRAME_CHECKER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== hdl/bfc_pkg.sv =====
`default_nettype none

package bfc_pkg;

	localparam int unsigned M_TDATA_W = 80;
	localparam int unsigned M_TUSER_W = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [11:0] POS_SAT = 12'd4095;

	localparam logic [31:0] MAGIC_RESET = 32'h4543_4542;
	localparam logic [7:0] MAJOR_RESET = 8'd1;
	localparam logic [7:0] MINOR_RESET = 8'd1;
	localparam logic [7:0] FLAG_ON = 8'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAJOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MINOR = 2'd2;

	typedef enum logic [1:0] {
		KIND_TYPE    = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_STATUS  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		STATUS_OK        = 4'd0,
		STATUS_SHORT     = 4'd1,
		STATUS_MAGIC     = 4'd2,
		STATUS_MAJOR     = 4'd3,
		STATUS_MINOR     = 4'd4,
		STATUS_CRCFLAG   = 4'd5,
		STATUS_CHECKFLAG = 4'd6,
		STATUS_CRC       = 4'd7,
		STATUS_CHECKWORD = 4'd8,
		STATUS_LENGTH    = 4'd9
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [31:0] seq;
		logic [31:0] len;
		status_t     status;
		logic        last;
	} res_t;

	function automatic logic [31:0] check_word(input logic [31:0] crc);
		logic [7:0] q0;
		logic [7:0] q1;
		logic [7:0] q2;
		logic [7:0] q3;
		q0 = {crc[20:16], 3'b000};
		q1 = {{2{crc[31]}}, crc[31:26]};
		q2 = {crc[2:0], 5'b00000};
		q3 = {{4{crc[15]}}, crc[15:12]};
		return {q3, q2, q1, q0};
	endfunction

endpackage

`default_nettype wire

// ===== hdl/bfc_crc_byte.sv =====
`default_nettype none

module bfc_crc_byte
	import bfc_pkg::*;
(
	input  wire logic [31:0] crc_in,
	input  wire logic [7:0]  data,
	output logic      [31:0] crc_out
);

	logic [31:0] c;

	always_comb begin
		c = crc_in ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
		end
		crc_out = c;
	end

endmodule

`default_nettype wire

// ===== hdl/bus_frame_checker_core.sv =====
// Frame checker: takes one frame byte per item on the input stream and forwards the type and
// payload bytes as they arrive; the byte marked last yields one status item carrying the sequence
// number, the declared length and the first error found, and the frame state then returns to its
// reset value. A byte is accepted in every cycle while s_tready is high; its item is registered
// in the output register, or in the skid register under a stall. The path that sets the clock is
// the byte-wide CRC-32 update and the position compares. The two-entry output buffer lets input
// flow on under a stall until the skid register fills, then holds it off until the output drains.
// The magic, major and minor registers may be written only while no frame is in progress.
`default_nettype none

module bus_frame_checker_core
	import bfc_pkg::*;
#(
	parameter int unsigned TYPE_LEN = 16,
	parameter int unsigned MAX_PAYLOAD = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,  // rx_byte
	input  wire logic                  s_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_TDATA_W-1:0]       m_tdata,  // out_byte, sequence_res, declared_length, status
	output logic [M_TUSER_W-1:0]       m_tuser,  // item_kind
	output logic                       m_tlast,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [11:0] SEQ_START = 12'd24;
	localparam logic [11:0] TYPE_START = 12'd28;
	localparam logic [11:0] TYPE_END = 12'(28 + TYPE_LEN);
	localparam logic [11:0] HDR_LEN = 12'(32 + TYPE_LEN);
	localparam logic [12:0] FRAME_MIN = 13'(40 + TYPE_LEN);
	localparam logic [31:0] MAX_LEN = 32'(MAX_PAYLOAD);

	logic [31:0] magic_q;
	logic [7:0]  major_q;
	logic [7:0]  minor_q;

	logic [11:0] pos_q;
	logic [31:0] crc_q;
	logic [31:0] snap_q;
	status_t     ferr_q;
	logic [31:0] seq_q;
	logic [31:0] len_q;
	logic [31:0] rcrc_q;
	logic [31:0] rcheck_q;

	logic [31:0] crc_next;
	logic [31:0] snap_next;
	logic [31:0] seq_next;
	logic [31:0] len_next;
	logic [31:0] rcrc_next;
	logic [31:0] rcheck_next;
	status_t     hdr_err;
	status_t     ferr_next;
	status_t     status_fin;
	logic [11:0] pos_inc;
	logic [12:0] n;
	logic [32:0] pos_x;
	logic [32:0] pay_end;
	logic [32:0] need;
	logic [7:0]  magic_byte;
	logic [7:0]  rx_byte;
	logic        fwd;
	kind_t       fwd_kind;
	logic        accept;
	logic        push;
	res_t        res;

	res_t        out_q;
	logic        out_valid_q;
	res_t        skid_q;
	logic        skid_valid_q;

	assign rx_byte = s_tdata;
	assign accept = s_tvalid && s_tready;
	assign s_tready = ~skid_valid_q;

	bfc_crc_byte u_crc (
		.crc_in  (crc_q),
		.data    (rx_byte),
		.crc_out (crc_next)
	);

	always_comb begin
		case (pos_q[1:0])
			2'd0:    magic_byte = magic_q[31:24];
			2'd1:    magic_byte = magic_q[23:16];
			2'd2:    magic_byte = magic_q[15:8];
			default: magic_byte = magic_q[7:0];
		endcase
	end

	always_comb begin
		hdr_err = STATUS_OK;
		seq_next = seq_q;
		len_next = len_q;
		snap_next = snap_q;
		rcrc_next = rcrc_q;
		rcheck_next = rcheck_q;
		fwd = 1'b0;
		fwd_kind = KIND_TYPE;
		pos_x = {21'd0, pos_q};
		pay_end = {21'd0, HDR_LEN} + {1'b0, len_q};

		if (pos_q < 12'd4) begin
			if (rx_byte != magic_byte) hdr_err = STATUS_MAGIC;
		end else if (pos_q == 12'd4) begin
			if (rx_byte != major_q) hdr_err = STATUS_MAJOR;
		end else if (pos_q == 12'd5) begin
			if (rx_byte != minor_q) hdr_err = STATUS_MINOR;
		end else if (pos_q == 12'd6) begin
			if (rx_byte != FLAG_ON) hdr_err = STATUS_CRCFLAG;
		end else if (pos_q == 12'd7) begin
			if (rx_byte != FLAG_ON) hdr_err = STATUS_CHECKFLAG;
		end else if (pos_q >= SEQ_START && pos_q < TYPE_START) begin
			seq_next = {seq_q[23:0], rx_byte};
		end else if (pos_q >= TYPE_START && pos_q < TYPE_END) begin
			fwd = 1'b1;
			fwd_kind = KIND_TYPE;
		end else if (pos_q >= TYPE_END && pos_q < HDR_LEN) begin
			len_next = {len_q[23:0], rx_byte};
		end else if (pos_q >= HDR_LEN) begin
			if (pos_x < pay_end) begin
				fwd = 1'b1;
				fwd_kind = KIND_PAYLOAD;
			end else if (pos_x < pay_end + 33'd4) begin
				if (pos_x == pay_end) snap_next = ~crc_q;
				rcrc_next = {rcrc_q[23:0], rx_byte};
			end else if (pos_x < pay_end + 33'd8) begin
				rcheck_next = {rcheck_q[23:0], rx_byte};
			end
		end

		ferr_next = (ferr_q != STATUS_OK) ? ferr_q : hdr_err;
		pos_inc = (pos_q < POS_SAT) ? pos_q + 12'd1 : POS_SAT;
		n = {1'b0, pos_q} + 13'd1;
		need = {20'd0, FRAME_MIN} + {1'b0, len_next};

		if (n <= FRAME_MIN) begin
			status_fin = STATUS_SHORT;
		end else if (ferr_next != STATUS_OK) begin
			status_fin = ferr_next;
		end else if (len_next > MAX_LEN || {20'd0, n} < need || n > {1'b0, POS_SAT}) begin
			status_fin = STATUS_LENGTH;
		end else if (rcrc_next != snap_next) begin
			status_fin = STATUS_CRC;
		end else if (rcheck_next != check_word(rcrc_next)) begin
			status_fin = STATUS_CHECKWORD;
		end else if ({20'd0, n} != need) begin
			status_fin = STATUS_LENGTH;
		end else begin
			status_fin = STATUS_OK;
		end

		if (s_tlast) begin
			res.kind = KIND_STATUS;
			res.data = 8'd0;
			res.seq = seq_next;
			res.len = len_next;
			res.status = status_fin;
			res.last = 1'b1;
		end else begin
			res.kind = fwd_kind;
			res.data = rx_byte;
			res.seq = 32'd0;
			res.len = 32'd0;
			res.status = STATUS_OK;
			res.last = 1'b0;
		end
		push = accept && (s_tlast || fwd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= MAGIC_RESET;
			major_q <= MAJOR_RESET;
			minor_q <= MINOR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAGIC: magic_q <= cfg_data;
				CFG_MAJOR: major_q <= cfg_data[7:0];
				CFG_MINOR: minor_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 12'd0;
			crc_q <= '1;
			snap_q <= 32'd0;
			ferr_q <= STATUS_OK;
			seq_q <= 32'd0;
			len_q <= 32'd0;
			rcrc_q <= 32'd0;
			rcheck_q <= 32'd0;
		end else if (accept) begin
			if (s_tlast) begin
				pos_q <= 12'd0;
				crc_q <= '1;
				snap_q <= 32'd0;
				ferr_q <= STATUS_OK;
				seq_q <= 32'd0;
				len_q <= 32'd0;
				rcrc_q <= 32'd0;
				rcheck_q <= 32'd0;
			end else begin
				pos_q <= pos_inc;
				crc_q <= crc_next;
				snap_q <= snap_next;
				ferr_q <= ferr_next;
				seq_q <= seq_next;
				len_q <= len_next;
				rcrc_q <= rcrc_next;
				rcheck_q <= rcheck_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {4'd0, out_q.status, out_q.len, out_q.seq, out_q.data};
	assign m_tuser = out_q.kind;
	assign m_tlast = out_q.last;

endmodule

`default_nettype wire

// ===== hdl/bfc_checker.sv =====
`default_nettype none
`include "bus_frame_checker_core_assert.svh"

module bfc_checker
	import bfc_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic [M_TUSER_W-1:0] m_tuser,
	input wire logic                 m_tlast
);

	// A stalled item must stay offered.
	`BFC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "output item dropped while stalled")

	// The status item is the only one that closes a frame.
	`BFC_ASSERT_SAME(a_last_kind, clk, arst_n, m_tvalid, m_tlast == (m_tuser == KIND_STATUS), "last mark and item kind disagree")

	// Forwarded bytes carry no sequence, length or status.
	`BFC_ASSERT_SAME(a_fwd_clean, clk, arst_n, m_tvalid && !m_tlast, m_tdata[79:8] == 72'd0 && (m_tuser == KIND_TYPE || m_tuser == KIND_PAYLOAD), "forwarded item carries stray fields")

	// A status item has no data byte and a known status code.
	`BFC_ASSERT_SAME(a_status_code, clk, arst_n, m_tvalid && m_tlast, m_tdata[7:0] == 8'd0 && m_tdata[79:76] == 4'd0 && m_tdata[75:72] <= STATUS_LENGTH, "malformed status item")

endmodule

bind bus_frame_checker_core bfc_checker u_bfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
